>>> rtl/core/cie_cmf_pkg.sv
// constants, lobe coefficients and types for the colour-matching gaussian fit
package cie_cmf_pkg;

  localparam int EXP_TABLE_DEPTH_DEF = 1024;
  localparam int EXP_ARG_LIMIT_DEF   = 16;

  localparam int WL_W     = 14;
  localparam int CMF_W    = 16;
  localparam int MU_W     = 18;
  localparam int INV_W    = 13;
  localparam int ALPHA_W  = 15;
  localparam int LOBE_CNT = 7;

  typedef enum logic [1:0] {
    CH_X,
    CH_Y,
    CH_Z
  } chan_t;

  typedef struct packed {
    logic signed [ALPHA_W-1:0] alpha;
    logic [MU_W-1:0]           mu;
    logic [INV_W-1:0]          inv_lo;
    logic [INV_W-1:0]          inv_hi;
    chan_t                     chan;
  } lobe_t;

  // alpha q13, centre q8, inverse widths q16
  localparam lobe_t LOBES [LOBE_CNT] = '{
    '{ 15'sd2966, 18'd113152, 13'd4089, 13'd2451, CH_X},
    '{ 15'sd8651, 18'd153549, 13'd1730, 13'd2117, CH_X},
    '{-15'sd532,  18'd128282, 13'd3211, 13'd2503, CH_X},
    '{ 15'sd6726, 18'd145613, 13'd1396, 13'd1619, CH_Y},
    '{ 15'sd2343, 18'd135910, 13'd4017, 13'd2110, CH_Y},
    '{ 15'sd9970, 18'd111872, 13'd5538, 13'd1822, CH_Z},
    '{ 15'sd5579, 18'd117504, 13'd2523, 13'd4751, CH_Z}
  };

endpackage

>>> rtl/core/cie_cmf_gaussian_fit.sv
// colour-matching gaussian fit pipeline: seven lobes, exp table, channel sums
// an accepted transaction reaches the outputs through the nine registered stages
// throughput: one transaction per cycle; bubbles collapse, so input is only
// stalled when all nine stages hold a transaction and the output is stalled
// exp(-t) is a constant table read through one registered port per lobe
// reset (rst, synchronous) clears all stage valid bits; data registers are not reset
module cie_cmf_gaussian_fit #(
  parameter int EXP_TABLE_DEPTH = cie_cmf_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int EXP_ARG_LIMIT   = cie_cmf_pkg::EXP_ARG_LIMIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cie_cmf_pkg::WL_W-1:0]          wavelength_q4,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cie_cmf_pkg::CMF_W-1:0]  x_bar,
  output logic signed [cie_cmf_pkg::CMF_W-1:0]  y_bar,
  output logic signed [cie_cmf_pkg::CMF_W-1:0]  z_bar
);

  localparam int NL     = cie_cmf_pkg::LOBE_CNT;
  localparam int NS     = 9;
  localparam int ST_IN  = 0;
  localparam int ST_OUT = NS - 1;

  localparam int ENT_W   = 17;
  localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int S12_W   = 20;
  localparam int SQ_IN_W = 15;
  localparam int SQ_W    = 2 * SQ_IN_W;
  localparam int NUM_W   = SQ_W + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int Q_W     = NUM_W - 25;
  localparam int L_SH    = $clog2(EXP_ARG_LIMIT);
  localparam int RCP_W   = Q_W + 2;
  localparam int QM_W    = Q_W + RCP_W;
  localparam int LOBE_W  = 32;
  localparam int ACC_W   = 35;

  localparam logic [NUM_W-1:0] HALF_DEN = NUM_W'(EXP_ARG_LIMIT) << 24;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << (Q_W + L_SH)) + 64'(EXP_ARG_LIMIT) - 64'd1) / 64'(EXP_ARG_LIMIT));

  function automatic logic [63:0] div_small(input logic [63:0] t, input int n);
    logic [63:0] r;
    case (n)
      1:       r = t;
      2:       r = t / 64'd2;
      3:       r = t / 64'd3;
      4:       r = t / 64'd4;
      5:       r = t / 64'd5;
      6:       r = t / 64'd6;
      7:       r = t / 64'd7;
      8:       r = t / 64'd8;
      9:       r = t / 64'd9;
      10:      r = t / 64'd10;
      11:      r = t / 64'd11;
      12:      r = t / 64'd12;
      default: r = t;
    endcase
    return r;
  endfunction

  // exp(-k * limit / depth) in q16 via taylor series on t/64, squared six times
  function automatic logic [ENT_W-1:0] exp_entry(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (k * 64'(EXP_ARG_LIMIT) * (64'd1 << 30)) / 64'(EXP_TABLE_DEPTH);
    y    = x >> 6;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = div_small((term * y) >> 30, n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int i = 0; i < 6; i++) begin
      sum = (sum * sum + (64'd1 << 29)) >> 30;
    end
    return ENT_W'((sum + (64'd1 << 13)) >> 14);
  endfunction

  function automatic logic [EXP_TABLE_DEPTH*ENT_W-1:0] build_rom();
    logic [EXP_TABLE_DEPTH*ENT_W-1:0] r;
    r = '0;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      r[k*ENT_W +: ENT_W] = exp_entry(64'(k));
    end
    return r;
  endfunction

  localparam logic [EXP_TABLE_DEPTH*ENT_W-1:0] EXP_ROM = build_rom();

  function automatic logic signed [cie_cmf_pkg::CMF_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] r;
    r = (a + ACC_W'(32768)) >>> 16;
    if (r > ACC_W'(32767)) begin
      return 16'sh7fff;
    end else if (r < -ACC_W'(32768)) begin
      return 16'sh8000;
    end
    return r[cie_cmf_pkg::CMF_W-1:0];
  endfunction

  // stage control
  logic [NS-1:0] vld;
  logic [NS-1:0] ld;

  always_comb begin
    ld[ST_OUT] = !vld[ST_OUT] || !out_stall;
    for (int s = ST_OUT - 1; s >= 0; s--) begin
      ld[s] = !vld[s] || ld[s+1];
    end
  end

  assign in_stall  = !ld[ST_IN];
  assign out_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[ST_IN]) begin
        vld[ST_IN] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (ld[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // datapath registers
  logic [cie_cmf_pkg::WL_W-1:0]  wl;
  logic [cie_cmf_pkg::MU_W-1:0]  mag     [NL];
  logic [cie_cmf_pkg::INV_W-1:0] inv     [NL];
  logic [S12_W-1:0]              s12     [NL];
  logic [SQ_W-1:0]               sq      [NL];
  logic                          ovf_d   [NL];
  logic [Q_W-1:0]                quo     [NL];
  logic                          ovf_e   [NL];
  logic [IDX_W-1:0]              idx     [NL];
  logic                          zero_f  [NL];
  logic [ENT_W-1:0]              rom_q   [NL];
  logic                          zero_g  [NL];
  logic signed [LOBE_W-1:0]      lobe    [NL];

  always_ff @(posedge clk) begin
    if (ld[ST_IN]) begin
      wl <= wavelength_q4;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lobe
    localparam cie_cmf_pkg::lobe_t LB = cie_cmf_pkg::LOBES[l];

    logic [cie_cmf_pkg::MU_W-1:0] w_q8;
    logic [31:0]                  prod;
    logic [NUM_W-1:0]             num;
    logic [QM_W-1:0]              qm;
    logic [Q_W-1:0]               idx_full;
    logic signed [LOBE_W-1:0]     a_ext;
    logic signed [LOBE_W-1:0]     e_ext;

    assign w_q8     = {wl, 4'b0000};
    assign prod     = 32'(mag[l]) * 32'(inv[l]);
    assign num      = NUM_W'(sq[l]) * NUM_W'(EXP_TABLE_DEPTH) + HALF_DEN;
    assign qm       = QM_W'(quo[l]) * QM_W'(RECIP);
    assign idx_full = Q_W'(qm >> (Q_W + L_SH));
    assign a_ext    = LOBE_W'(LB.alpha);
    assign e_ext    = $signed(LOBE_W'(rom_q[l]));

    always_ff @(posedge clk) begin
      if (ld[1]) begin
        if (w_q8 >= LB.mu) begin
          mag[l] <= w_q8 - LB.mu;
          inv[l] <= LB.inv_hi;
        end else begin
          mag[l] <= LB.mu - w_q8;
          inv[l] <= LB.inv_lo;
        end
      end
      if (ld[2]) begin
        s12[l] <= S12_W'((prod + 32'd2048) >> 12);
      end
      if (ld[3]) begin
        ovf_d[l] <= |s12[l][S12_W-1:SQ_IN_W];
        sq[l]    <= SQ_W'(32'(s12[l][SQ_IN_W-1:0]) * 32'(s12[l][SQ_IN_W-1:0]));
      end
      if (ld[4]) begin
        quo[l]   <= Q_W'(num >> 25);
        ovf_e[l] <= ovf_d[l];
      end
      if (ld[5]) begin
        idx[l]    <= idx_full[IDX_W-1:0];
        zero_f[l] <= ovf_e[l] || (idx_full >= Q_W'(EXP_TABLE_DEPTH));
      end
      if (ld[6]) begin
        rom_q[l]  <= EXP_ROM[idx[l]*ENT_W +: ENT_W];
        zero_g[l] <= zero_f[l];
      end
      if (ld[7]) begin
        lobe[l] <= zero_g[l] ? '0 : a_ext * e_ext;
      end
    end
  end

  // channel sums, rounding and saturation
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_z;

  always_comb begin
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    for (int l = 0; l < NL; l++) begin
      case (cie_cmf_pkg::LOBES[l].chan)
        cie_cmf_pkg::CH_X: acc_x = acc_x + ACC_W'(lobe[l]);
        cie_cmf_pkg::CH_Y: acc_y = acc_y + ACC_W'(lobe[l]);
        cie_cmf_pkg::CH_Z: acc_z = acc_z + ACC_W'(lobe[l]);
        default:           acc_x = acc_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      x_bar <= round_sat(acc_x);
      y_bar <= round_sat(acc_y);
      z_bar <= round_sat(acc_z);
    end
  end

  // input only held back when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with a free stage");

  // a free-running output never backs up the input
  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output not stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("stage valid after reset");

  // a transaction stuck at the output while every stage is occupied stays at the output
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && (&vld)) |=> vld[ST_OUT])
    else $error("held transaction lost at output");

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the colour-matching gaussian fit pipeline
`timescale 1ns / 1ps

module tb_top;

  localparam int EXP_DEPTH = cie_cmf_pkg::EXP_TABLE_DEPTH_DEF;
  localparam int EXP_LIMIT = cie_cmf_pkg::EXP_ARG_LIMIT_DEF;
  localparam int WL_W      = cie_cmf_pkg::WL_W;
  localparam int CMF_W     = cie_cmf_pkg::CMF_W;
  localparam longint unsigned Q30 = 64'd1 << 30;

  typedef struct packed {
    int                  alpha;
    int                  mu;
    int                  inv_lo;
    int                  inv_hi;
    cie_cmf_pkg::chan_t  ch;
  } lobe_coef_t;

  typedef struct {
    logic [WL_W-1:0]         wl;
    logic signed [CMF_W-1:0] x;
    logic signed [CMF_W-1:0] y;
    logic signed [CMF_W-1:0] z;
  } cmf_t;

  // alpha q13, centre q8, inverse widths q16
  localparam lobe_coef_t FIT [7] = '{
    '{ 2966, 113152, 4089, 2451, cie_cmf_pkg::CH_X},
    '{ 8651, 153549, 1730, 2117, cie_cmf_pkg::CH_X},
    '{ -532, 128282, 3211, 2503, cie_cmf_pkg::CH_X},
    '{ 6726, 145613, 1396, 1619, cie_cmf_pkg::CH_Y},
    '{ 2343, 135910, 4017, 2110, cie_cmf_pkg::CH_Y},
    '{ 9970, 111872, 5538, 1822, cie_cmf_pkg::CH_Z},
    '{ 5579, 117504, 2523, 4751, cie_cmf_pkg::CH_Z}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [WL_W-1:0]         wavelength_q4 = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [CMF_W-1:0] x_bar;
  logic signed [CMF_W-1:0] y_bar;
  logic signed [CMF_W-1:0] z_bar;

  longint unsigned exp_q16 [EXP_DEPTH];
  logic [WL_W-1:0] wl_pending [$];
  cmf_t            cmf_expected [$];
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     fail_count = 0;

  cie_cmf_gaussian_fit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .wavelength_q4(wavelength_q4),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .x_bar        (x_bar),
    .y_bar        (y_bar),
    .z_bar        (z_bar)
  );

  always #6 clk = ~clk;

  function automatic void build_exp_table();
    longint unsigned x, y, term, sum;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      x = (longint'(k) * EXP_LIMIT * Q30) / EXP_DEPTH;
      y = x >> 6;
      term = Q30;
      sum = Q30;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * y) >> 30) / n;
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      for (int i = 0; i < 6; i++) sum = (sum * sum + (Q30 >> 1)) >> 30;
      exp_q16[k] = (sum + (64'd1 << 13)) >> 14;
    end
  endfunction

  function automatic logic signed [CMF_W-1:0] round_sat_q13(longint acc_q29);
    longint v;
    v = (acc_q29 + 32768) >>> 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CMF_W-1:0];
  endfunction

  function automatic cmf_t predict_cmf(logic [WL_W-1:0] wl);
    longint w8, d, mag, inv, s12, num, den, idx;
    longint acc [3];
    cmf_t r;
    w8 = longint'(wl) << 4;
    den = longint'(EXP_LIMIT) << 25;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int i = 0; i < 7; i++) begin
      d = w8 - FIT[i].mu;
      mag = (d < 0) ? -d : d;
      inv = (d < 0) ? FIT[i].inv_lo : FIT[i].inv_hi;
      s12 = (mag * inv + 2048) >>> 12;
      num = s12 * s12 * EXP_DEPTH;
      idx = (num + den / 2) / den;
      if (idx < EXP_DEPTH)
        acc[int'(FIT[i].ch)] += longint'(FIT[i].alpha) * longint'(exp_q16[idx]);
    end
    r.wl = wl;
    r.x = round_sat_q13(acc[int'(cie_cmf_pkg::CH_X)]);
    r.y = round_sat_q13(acc[int'(cie_cmf_pkg::CH_Y)]);
    r.z = round_sat_q13(acc[int'(cie_cmf_pkg::CH_Z)]);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!in_valid || !in_stall) begin
        if (wl_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          wavelength_q4 <= wl_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cmf_t e;
    if (!rst) begin
      if (in_valid && !in_stall) cmf_expected.push_back(predict_cmf(wavelength_q4));
      if (out_valid && !out_stall) begin
        if (cmf_expected.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          e = cmf_expected.pop_front();
          if (x_bar !== e.x) begin
            $error("x_bar (wl %0d): expected %0d, actual %0d", e.wl, e.x, x_bar);
            fail_count++;
          end
          if (y_bar !== e.y) begin
            $error("y_bar (wl %0d): expected %0d, actual %0d", e.wl, e.y, y_bar);
            fail_count++;
          end
          if (z_bar !== e.z) begin
            $error("z_bar (wl %0d): expected %0d, actual %0d", e.wl, e.z, z_bar);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic push_random(int unsigned count);
    repeat (count) begin
      if ($urandom_range(99) < 80) wl_pending.push_back(WL_W'($urandom_range(13600, 5600)));
      else wl_pending.push_back(WL_W'($urandom_range(16383)));
    end
  endtask

  task automatic drain();
    while (wl_pending.size() != 0 || in_valid || cmf_expected.size() != 0) @(negedge clk);
  endtask

  initial begin
    build_exp_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // range ends, exact centres, centres straddled, visible band edges
    wl_pending = '{14'd0, 14'd16383, 14'd1, 14'd8191, 14'd8192, 14'd7072, 14'd6992,
                   14'd7344, 14'd9596, 14'd9597, 14'd8017, 14'd8018, 14'd9100, 14'd9101,
                   14'd8494, 14'd8495, 14'd5760, 14'd13280, 14'h2AAA, 14'h1555};
    push_random(258);
    drain();

    send_idle_pct = 70;
    recv_stall_pct = 0;
    push_random(258);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 70;
    push_random(258);
    drain();

    send_idle_pct = 10;
    recv_stall_pct = 10;
    push_random(258);
    drain();

    repeat (16) @(negedge clk);
    if (fail_count == 0 && cmf_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(64'd300000 * 12);
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/core/cie_cmf_pkg.sv
rtl/core/cie_cmf_gaussian_fit.sv
verif/tb_top.sv
